// File: design/dots_pkg.sv
`timescale 1ns / 1ps

package dots_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TIME_W     = 63;
  localparam int TIMER_ID_W = 4;
  localparam int KIND_W     = 2;

  localparam logic [KIND_W-1:0] KIND_ARM    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic restart;    // rewind scan counter, drop running best
    logic issue;      // read table entry at scan counter, advance
    logic pick;       // issued entry belongs to an ordering pass
    logic commit;     // disarm expired set, latch remaining earliest
    logic emit;       // drive one fired result
    logic emit_none;  // drive the empty result of a quiet tick
  } dots_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // scan counter sits on the last entry
    logic fire_any;   // expired set not yet emptied
    logic emit_last;  // picked timer is the only one left in the set
  } dots_stat_t;

endpackage

// File: design/dots_ctrl.sv
`timescale 1ns / 1ps

module dots_ctrl import dots_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KIND_W-1:0] in_kind,
  input  dots_stat_t        stat,
  output dots_cmd_t         cmd,
  output logic              busy
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_SURVEY     = 3'd1;
  localparam logic [2:0] S_SURVEY_END = 3'd2;
  localparam logic [2:0] S_COMMIT     = 3'd3;
  localparam logic [2:0] S_NONE       = 3'd4;
  localparam logic [2:0] S_PICK       = 3'd5;
  localparam logic [2:0] S_PICK_END   = 3'd6;
  localparam logic [2:0] S_EMIT       = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start && (in_kind == KIND_TICK)) begin
          cmd.restart = 1'b1;
          state_nxt   = S_SURVEY;
        end
      end
      S_SURVEY: begin
        cmd.issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_SURVEY_END;
        end
      end
      S_SURVEY_END: begin
        // last entry still in flight
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit  = 1'b1;
        cmd.restart = 1'b1;
        state_nxt   = stat.fire_any ? S_PICK : S_NONE;
      end
      S_NONE: begin
        cmd.emit_none = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_PICK: begin
        cmd.issue = 1'b1;
        cmd.pick  = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_PICK_END;
        end
      end
      S_PICK_END: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit    = 1'b1;
        cmd.restart = 1'b1;
        state_nxt   = stat.emit_last ? S_IDLE : S_PICK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: design/dots_dp.sv
`timescale 1ns / 1ps

module dots_dp import dots_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_accept,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [TIMER_ID_W-1:0] in_timer_id,
  input  logic [TIME_W-1:0]     in_expiry_time,
  input  logic [TIME_W-1:0]     in_current_time,
  input  dots_cmd_t             cmd,
  output dots_stat_t            stat,
  output logic                  out_valid,
  output logic                  out_fired,
  output logic [TIMER_ID_W-1:0] out_fired_timer_id,
  output logic                  out_last,
  output logic                  out_any_armed,
  output logic [TIME_W-1:0]     out_next_expiry
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  logic [TIME_W-1:0] exp_mem [NUM_TIMERS];

  logic [TIME_W-1:0]     now_r;
  logic [IDX_W-1:0]      cnt_r;
  logic [TIME_W-1:0]     rd_data_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  p_vld_r;
  logic                  p_pick_r;
  logic [NUM_TIMERS-1:0] armed_r;
  logic [NUM_TIMERS-1:0] armed_nxt;
  logic [NUM_TIMERS-1:0] fire_r;
  logic [NUM_TIMERS-1:0] fire_nxt;
  logic                  best_vld_r;
  logic [TIME_W-1:0]     best_r;
  logic [IDX_W-1:0]      best_id_r;
  logic                  any_r;
  logic [TIME_W-1:0]     next_r;
  logic                  out_valid_r;
  logic                  out_fired_r;
  logic [TIMER_ID_W-1:0] out_id_r;
  logic                  out_last_r;

  logic                  id_ok;
  logic [IDX_W-1:0]      wr_idx;
  logic                  arm_wr;
  logic                  cancel_wr;
  logic                  le_now;
  logic                  lt_best;
  logic                  survey_hit;
  logic                  take;
  logic [NUM_TIMERS-1:0] pick_mask;

  assign id_ok     = (32'(in_timer_id) < NUM_TIMERS);
  assign wr_idx    = IDX_W'(in_timer_id);
  assign arm_wr    = in_accept && (in_kind == KIND_ARM) && id_ok;
  assign cancel_wr = in_accept && (in_kind == KIND_CANCEL) && id_ok;

  assign le_now  = (rd_data_r <= now_r);
  assign lt_best = !best_vld_r || (rd_data_r < best_r);

  // survey pass: split armed timers into expired and remaining earliest
  // ordering pass: earliest of the expired set, lowest id wins ties
  assign survey_hit = p_vld_r && !p_pick_r && armed_r[idx_r] && le_now;
  assign take       = p_vld_r && (p_pick_r ? (fire_r[idx_r] && lt_best)
                                           : (armed_r[idx_r] && !le_now && lt_best));

  always_comb begin
    pick_mask = '0;
    pick_mask[best_id_r] = 1'b1;
  end

  assign stat.scan_last = (cnt_r == LAST_IDX);
  assign stat.fire_any  = |fire_r;
  assign stat.emit_last = ((fire_r & ~pick_mask) == '0);

  always_comb begin
    armed_nxt = armed_r;
    if (arm_wr) begin
      armed_nxt[wr_idx] = 1'b1;
    end
    if (cancel_wr) begin
      armed_nxt[wr_idx] = 1'b0;
    end
    if (cmd.commit) begin
      armed_nxt = armed_r & ~fire_r;
    end
  end

  always_comb begin
    fire_nxt = fire_r;
    if (survey_hit) begin
      fire_nxt[idx_r] = 1'b1;
    end
    if (cmd.emit) begin
      fire_nxt = fire_r & ~pick_mask;
    end
  end

  // expiry table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (arm_wr) begin
      exp_mem[wr_idx] <= in_expiry_time;
    end
    rd_data_r <= exp_mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_kind == KIND_TICK)) begin
      now_r <= in_current_time;
    end
    if (cmd.issue) begin
      idx_r <= cnt_r;
    end
    if (take) begin
      best_r    <= rd_data_r;
      best_id_r <= idx_r;
    end
    if (cmd.commit) begin
      any_r  <= best_vld_r;
      next_r <= best_vld_r ? best_r : '0;
    end
    if (cmd.emit) begin
      out_fired_r <= 1'b1;
      out_id_r    <= TIMER_ID_W'(best_id_r);
      out_last_r  <= stat.emit_last;
    end else if (cmd.emit_none) begin
      out_fired_r <= 1'b0;
      out_id_r    <= '0;
      out_last_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      p_vld_r     <= 1'b0;
      p_pick_r    <= 1'b0;
      armed_r     <= '0;
      fire_r      <= '0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_vld_r     <= cmd.issue;
      p_pick_r    <= cmd.pick;
      armed_r     <= armed_nxt;
      fire_r      <= fire_nxt;
      out_valid_r <= cmd.emit || cmd.emit_none;
      if (cmd.restart) begin
        cnt_r      <= '0;
        best_vld_r <= 1'b0;
      end else begin
        if (cmd.issue) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (take) begin
          best_vld_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fired          = out_fired_r;
  assign out_fired_timer_id = out_id_r;
  assign out_last           = out_last_r;
  assign out_any_armed      = any_r;
  assign out_next_expiry    = next_r;

endmodule

// File: design/deadline_ordered_timer_set.sv
`timescale 1ns / 1ps

// Bank of 16 one-shot timers with absolute 63-bit expiry times. Present an
// item with start while busy is low. Arm and cancel take effect at once and
// give no result; busy stays low. A tick raises busy and sweeps the expiry
// table once (one entry per cycle through its single read port) to collect
// the expired set and the earliest remaining expiry, then takes one more
// sweep per expired timer to put them in expiry order (ties by lowest id).
// After the survey sweep the tick commits, then either gives the empty result
// when nothing expires or runs one ordering sweep and emit per expired
// timer. Each result shows on the out_ ports for
// exactly one cycle with out_valid high; there is no back-pressure, so the
// receiver must take every beat as it comes. out_last marks the final beat
// of a tick; a quiet tick gives one beat with out_fired low.
module deadline_ordered_timer_set import dots_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [TIMER_ID_W-1:0] in_timer_id,
  input  logic [TIME_W-1:0]     in_expiry_time,
  input  logic [TIME_W-1:0]     in_current_time,
  output logic                  out_valid,
  output logic                  out_fired,
  output logic [TIMER_ID_W-1:0] out_fired_timer_id,
  output logic                  out_last,
  output logic                  out_any_armed,
  output logic [TIME_W-1:0]     out_next_expiry
);

  dots_cmd_t  cmd;
  dots_stat_t stat;
  logic       in_accept;

  assign in_accept = start && !busy;

  dots_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  dots_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_accept          (in_accept),
    .in_kind            (in_kind),
    .in_timer_id        (in_timer_id),
    .in_expiry_time     (in_expiry_time),
    .in_current_time    (in_current_time),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_fired          (out_fired),
    .out_fired_timer_id (out_fired_timer_id),
    .out_last           (out_last),
    .out_any_armed      (out_any_armed),
    .out_next_expiry    (out_next_expiry)
  );

endmodule

// File: test/tb_deadline_ordered_timer_set.sv
`timescale 1ns / 1ps

module tb_deadline_ordered_timer_set;
  import dots_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};
  localparam int                STALL_LIMIT = 2000;
  localparam int                TAIL_CYCLES = 400;

  typedef struct packed {
    logic                  fired;
    logic [TIMER_ID_W-1:0] timer_id;
    logic                  last;
    logic                  any_armed;
    logic [TIME_W-1:0]     next_expiry;
  } timer_beat_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [KIND_W-1:0]     in_kind;
  logic [TIMER_ID_W-1:0] in_timer_id;
  logic [TIME_W-1:0]     in_expiry_time;
  logic [TIME_W-1:0]     in_current_time;
  logic                  out_valid;
  logic                  out_fired;
  logic [TIMER_ID_W-1:0] out_fired_timer_id;
  logic                  out_last;
  logic                  out_any_armed;
  logic [TIME_W-1:0]     out_next_expiry;

  deadline_ordered_timer_set uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_timer_id        (in_timer_id),
    .in_expiry_time     (in_expiry_time),
    .in_current_time    (in_current_time),
    .out_valid          (out_valid),
    .out_fired          (out_fired),
    .out_fired_timer_id (out_fired_timer_id),
    .out_last           (out_last),
    .out_any_armed      (out_any_armed),
    .out_next_expiry    (out_next_expiry)
  );

  // shadow copy of the timer table
  logic              shadow_armed [NUM_TIMERS];
  logic [TIME_W-1:0] shadow_expiry [NUM_TIMERS];
  timer_beat_t       due_beats [$];
  int                error_count;
  int                stall_cycles;
  bit                watch_on;

  always #1 clk = ~clk;

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[TIME_W-1:0];
  endfunction

  function automatic int earliest_armed();
    int best;
    best = -1;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (shadow_armed[i] && (best < 0 || shadow_expiry[i] < shadow_expiry[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic void queue_beat(input timer_beat_t beat);
    due_beats = {due_beats, beat};
  endfunction

  // update the shadow table and queue the beats a tick must produce
  task automatic track_timer_item(input logic [KIND_W-1:0] k,
                                  input logic [TIMER_ID_W-1:0] id,
                                  input logic [TIME_W-1:0] exp_t,
                                  input logic [TIME_W-1:0] now_t);
    int          fired_ids [$];
    int          best;
    timer_beat_t beat;
    logic        any;
    logic [TIME_W-1:0] nxt;
    case (k)
      KIND_ARM: begin
        if (id < NUM_TIMERS) begin
          shadow_expiry[id] = exp_t;
          shadow_armed[id]  = 1'b1;
        end
      end
      KIND_CANCEL: begin
        if (id < NUM_TIMERS) shadow_armed[id] = 1'b0;
      end
      KIND_TICK: begin
        best = earliest_armed();
        while (best >= 0 && shadow_expiry[best] <= now_t) begin
          shadow_armed[best] = 1'b0;
          fired_ids = {fired_ids, best};
          best = earliest_armed();
        end
        any = (best >= 0);
        nxt = any ? shadow_expiry[best] : '0;
        if (fired_ids.size() == 0) begin
          beat = '{fired: 1'b0, timer_id: '0, last: 1'b1, any_armed: any, next_expiry: nxt};
          queue_beat(beat);
        end else begin
          foreach (fired_ids[j]) begin
            beat.fired       = 1'b1;
            beat.timer_id    = TIMER_ID_W'(fired_ids[j]);
            beat.last        = (j == fired_ids.size() - 1);
            beat.any_armed   = any;
            beat.next_expiry = nxt;
            queue_beat(beat);
          end
        end
      end
      default: ;
    endcase
  endtask

  // hold the item until the block takes it; start stays high afterwards
  task automatic send_item(input logic [KIND_W-1:0] k,
                           input logic [TIMER_ID_W-1:0] id,
                           input logic [TIME_W-1:0] exp_t,
                           input logic [TIME_W-1:0] now_t);
    @(negedge clk);
    start           <= 1'b1;
    in_kind         <= k;
    in_timer_id     <= id;
    in_expiry_time  <= exp_t;
    in_current_time <= now_t;
    do @(posedge clk); while (busy);
    track_timer_item(k, id, exp_t, now_t);
  endtask

  task automatic idle_burst();
    int n;
    n = $urandom_range(1, 7);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
  endtask

  task automatic test_quiet_tick();
    send_item(KIND_TICK, 4'd0, '0, '0);
  endtask

  task automatic test_arm_and_cancel();
    send_item(KIND_ARM, 4'd0, '0, TIME_MAX);
    send_item(KIND_ARM, 4'd15, TIME_MAX, '0);
    send_item(KIND_ARM, 4'd5, 63'd100, '0);
    // re-arm replaces the earlier expiry
    send_item(KIND_ARM, 4'd5, 63'd50, '0);
    send_item(KIND_CANCEL, 4'd7, TIME_MAX, TIME_MAX);
    send_item(KIND_CANCEL, 4'd15, '0, '0);
    send_item(KIND_UNUSED, 4'd15, 63'd1, 63'd1);
    send_item(KIND_TICK, 4'd9, '0, 63'd49);
    send_item(KIND_TICK, 4'd0, '0, TIME_MAX);
  endtask

  task automatic test_equal_expiries();
    for (int i = NUM_TIMERS - 1; i >= 0; i--)
      send_item(KIND_ARM, i[TIMER_ID_W-1:0], 63'd42, '0);
    send_item(KIND_TICK, 4'd0, '0, 63'd42);
  endtask

  function automatic logic [TIME_W-1:0] pick_epoch();
    case ($urandom_range(0, 2))
      0:       return TIME_W'($urandom_range(0, 100));
      1:       return rand_time();
      default: return TIME_MAX - TIME_W'($urandom_range(0, 150));
    endcase
  endfunction

  // arms cluster around a moving present time so ticks fire real sets
  task automatic test_random_traffic(input int n_items, input bit with_gaps);
    logic [TIME_W-1:0]     clock_base;
    logic [TIME_W-1:0]     exp_t;
    logic [TIME_W-1:0]     now_t;
    logic [KIND_W-1:0]     k;
    logic [TIMER_ID_W-1:0] id;
    int                    sel;
    clock_base = pick_epoch();
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 39) clock_base = pick_epoch();
      if (with_gaps && i == n_items / 2) wait_drained();
      if (with_gaps && $urandom_range(0, 3) == 0) idle_burst();
      id    = TIMER_ID_W'($urandom_range(0, 15));
      exp_t = rand_time();
      now_t = rand_time();
      sel   = $urandom_range(0, 99);
      if (sel < 45) begin
        k     = KIND_ARM;
        exp_t = clock_base + TIME_W'($urandom_range(0, 80));
      end else if (sel < 55) begin
        k = KIND_ARM;
      end else if (sel < 65) begin
        k = KIND_CANCEL;
      end else if (sel < 93) begin
        k     = KIND_TICK;
        now_t = clock_base + TIME_W'($urandom_range(0, 40));
        if ($urandom_range(0, 2) != 0) clock_base = now_t;
      end else if (sel < 96) begin
        k     = KIND_TICK;
        now_t = TIME_MAX;
      end else begin
        k = KIND_UNUSED;
      end
      send_item(k, id, exp_t, now_t);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected result beat fired=%0b id=%0d last=%0b", $realtime,
                 out_fired, out_fired_timer_id, out_last);
        error_count++;
      end else begin
        timer_beat_t want;
        want = due_beats.pop_front();
        if (out_fired !== want.fired) begin
          $display("%0t: fired expected %0b actual %0b", $realtime, want.fired, out_fired);
          error_count++;
        end
        if (out_fired_timer_id !== want.timer_id) begin
          $display("%0t: fired_timer_id expected %0d actual %0d", $realtime,
                   want.timer_id, out_fired_timer_id);
          error_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $realtime, want.last, out_last);
          error_count++;
        end
        if (out_any_armed !== want.any_armed) begin
          $display("%0t: any_armed expected %0b actual %0b", $realtime,
                   want.any_armed, out_any_armed);
          error_count++;
        end
        if (out_next_expiry !== want.next_expiry) begin
          $display("%0t: next_expiry expected %0h actual %0h", $realtime,
                   want.next_expiry, out_next_expiry);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (watch_on) begin
      if ((start && !busy) || out_valid) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_kind         = KIND_ARM;
    in_timer_id     = '0;
    in_expiry_time  = '0;
    in_current_time = '0;
    error_count     = 0;
    stall_cycles    = 0;
    watch_on        = 1'b0;
    foreach (shadow_armed[i]) begin
      shadow_armed[i]  = 1'b0;
      shadow_expiry[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n    <= 1'b1;
    watch_on <= 1'b1;

    test_quiet_tick();
    test_arm_and_cancel();
    test_equal_expiries();
    test_random_traffic(190, 1'b1);
    test_random_traffic(55, 1'b0);

    @(negedge clk);
    start <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
design/dots_pkg.sv
design/dots_ctrl.sv
design/dots_dp.sv
design/deadline_ordered_timer_set.sv
test/tb_deadline_ordered_timer_set.sv
